### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/mit_pkg.sv
// Types, constants and register indexes of the moving inversions test unit.
package mit_pkg;

  localparam int AddrWidth   = 30;
  localparam int DataWidth   = 32;
  localparam int FieldAddrW  = 30;
  localparam int CountWidth  = 31;
  localparam int ShiftWidth  = 6;
  localparam int PassWidth   = 8;
  localparam int OffsetWidth = 5;
  localparam int CfgIdxWidth = 3;

  localparam logic [CountWidth-1:0] WordLimit = CountWidth'(64'(1) << AddrWidth);

  localparam logic [DataWidth-1:0] LowWalkOne  = 32'h0000_0001;
  localparam logic [DataWidth-1:0] LowWalkZero = 32'hffff_fffe;
  localparam logic [DataWidth-1:0] TopWalkOne  = 32'h8000_0000;
  localparam logic [DataWidth-1:0] TopWalkZero = 32'h7fff_ffff;
  localparam logic [ShiftWidth-1:0] ShiftTop   = 6'd32;

  localparam logic KindStart = 1'b0;
  localparam logic KindRead  = 1'b1;

  localparam logic [CfgIdxWidth-1:0] RegBaseAddress    = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegWordCount      = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegFirstPattern   = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegShiftFill      = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegStartOffset    = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegIterationCount = 3'd5;
  localparam logic [CfgIdxWidth-1:0] RegPatternMode    = 3'd6;

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhFill = 2'd1,
    PhAsc  = 2'd2,
    PhDesc = 2'd3
  } phase_e;

  typedef struct packed {
    logic [FieldAddrW-1:0]  base_address;
    logic [CountWidth-1:0]  word_count;
    logic [DataWidth-1:0]   first_pattern;
    logic                   shift_fill;
    logic [OffsetWidth-1:0] start_offset;
    logic [PassWidth-1:0]   iteration_count;
    logic                   pattern_mode;
  } cfg_t;

  typedef struct packed {
    phase_e                phase;
    logic [AddrWidth-1:0]  word;
    logic [ShiftWidth-1:0] shift_pos;
    logic [DataWidth-1:0]  pattern;
    logic [PassWidth-1:0]  passes;
    logic [DataWidth-1:0]  errors;
  } state_t;

  typedef struct packed {
    logic [FieldAddrW-1:0] word_address;
    logic                  write_enable;
    logic [DataWidth-1:0]  write_data;
    logic [DataWidth-1:0]  expected_data;
    logic                  compare_valid;
    logic                  mismatch;
    logic [FieldAddrW-1:0] next_address;
    logic [DataWidth-1:0]  error_total;
    logic                  run_done;
  } result_t;

endpackage

### hw/rtl/moving_inversions_memory_test_unit.sv
// Moving inversions memory self-test sequencer: top level with input and result registers.
//
// Usage: write the configuration registers through cfg_valid_i / cfg_index_i / cfg_data_i
// (cfg_ready_o is always high) while no transfer is in flight. Send a kind 0 item to start
// a run; it handles the first word of the fill pass. Every later item carries, in
// read_data_i, the word read at the next_address of the previous result, with kind 1.
// Each input transfer yields exactly one result transfer.
// Path: the input transfer loads the input register, and the next-state step then loads the
// result register once that is empty or not stalled. Throughput: one item per cycle while
// out_stall_i is low, set by the single next-state step between the two registers.
// Stall: when out_stall_i holds the result register, one more item is taken into the
// input register; then in_stall_o rises until the result moves on. Nothing is dropped.
// Reset: configuration returns to its defaults (word count 1, one iteration), the
// sequencer goes idle with the error count cleared, both registers empty.
// An item of kind 1 while idle returns run_done with the current error total.
`include "assert_macros.svh"

module moving_inversions_memory_test_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                kind_i,
  input  logic [mit_pkg::DataWidth-1:0]       read_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [mit_pkg::FieldAddrW-1:0]      word_address_o,
  output logic                                write_enable_o,
  output logic [mit_pkg::DataWidth-1:0]       write_data_o,
  output logic [mit_pkg::DataWidth-1:0]       expected_data_o,
  output logic                                compare_valid_o,
  output logic                                mismatch_o,
  output logic [mit_pkg::FieldAddrW-1:0]      next_address_o,
  output logic [mit_pkg::DataWidth-1:0]       error_total_o,
  output logic                                run_done_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mit_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [mit_pkg::DataWidth-1:0]       cfg_data_i
);

  mit_pkg::cfg_t                 cfg;
  mit_pkg::state_t               state_q;
  mit_pkg::state_t               state_d;
  mit_pkg::result_t              result_d;
  mit_pkg::result_t              result_q;
  logic                          in_valid_q;
  logic                          in_valid_d;
  logic                          kind_q;
  logic [mit_pkg::DataWidth-1:0] read_data_q;
  logic                          out_valid_q;
  logic                          out_valid_d;
  logic                          advance;
  logic                          in_xfer;

  mit_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mit_step u_step (
    .cfg_i       (cfg),
    .state_i     (state_q),
    .kind_i      (kind_q),
    .read_data_i (read_data_q),
    .state_o     (state_d),
    .result_o    (result_d)
  );

  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign in_valid_d  = in_xfer || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{phase: mit_pkg::PhIdle, default: '0};
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q      <= kind_i;
      read_data_q <= read_data_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign word_address_o  = result_q.word_address;
  assign write_enable_o  = result_q.write_enable;
  assign write_data_o    = result_q.write_data;
  assign expected_data_o = result_q.expected_data;
  assign compare_valid_o = result_q.compare_valid;
  assign mismatch_o      = result_q.mismatch;
  assign next_address_o  = result_q.next_address;
  assign error_total_o   = result_q.error_total;
  assign run_done_o      = result_q.run_done;

  `ASSERT_NEXT(a_err_monotonic, !(advance && (kind_q == mit_pkg::KindStart)),
               state_q.errors >= $past(state_q.errors))
  `ASSERT_NOW(a_mismatch_in_check, out_valid_q && mismatch_o, compare_valid_o)
  `ASSERT_NEXT(a_hold_pending, in_valid_q && out_valid_q && out_stall_i,
               in_valid_q && out_valid_q)

endmodule

### hw/rtl/mit_cfg.sv
// Configuration register file of the moving inversions test unit.
module mit_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mit_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  logic [mit_pkg::DataWidth-1:0]     cfg_data_i,
  output mit_pkg::cfg_t                     cfg_o
);

  mit_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_address    <= '0;
      cfg_q.word_count      <= mit_pkg::CountWidth'(1);
      cfg_q.first_pattern   <= '0;
      cfg_q.shift_fill      <= 1'b0;
      cfg_q.start_offset    <= '0;
      cfg_q.iteration_count <= mit_pkg::PassWidth'(1);
      cfg_q.pattern_mode    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mit_pkg::RegBaseAddress: begin
          cfg_q.base_address <= cfg_data_i[mit_pkg::FieldAddrW-1:0];
        end
        mit_pkg::RegWordCount: begin
          cfg_q.word_count <= cfg_data_i[mit_pkg::CountWidth-1:0];
        end
        mit_pkg::RegFirstPattern: begin
          cfg_q.first_pattern <= cfg_data_i;
        end
        mit_pkg::RegShiftFill: begin
          cfg_q.shift_fill <= cfg_data_i[0];
        end
        mit_pkg::RegStartOffset: begin
          cfg_q.start_offset <= cfg_data_i[mit_pkg::OffsetWidth-1:0];
        end
        mit_pkg::RegIterationCount: begin
          cfg_q.iteration_count <= cfg_data_i[mit_pkg::PassWidth-1:0];
        end
        mit_pkg::RegPatternMode: begin
          cfg_q.pattern_mode <= cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### hw/rtl/mit_step.sv
// Next-state and result logic for one visited word of a moving inversions run.
module mit_step (
  input  mit_pkg::cfg_t                 cfg_i,
  input  mit_pkg::state_t               state_i,
  input  logic                          kind_i,
  input  logic [mit_pkg::DataWidth-1:0] read_data_i,
  output mit_pkg::state_t               state_o,
  output mit_pkg::result_t              result_o
);

  logic [mit_pkg::AddrWidth:0] count;
  logic [mit_pkg::AddrWidth:0] last_idx;

  always_comb begin
    if (cfg_i.word_count == '0) begin
      count = (mit_pkg::AddrWidth+1)'(1);
    end else if (cfg_i.word_count > mit_pkg::WordLimit) begin
      count = mit_pkg::WordLimit[mit_pkg::AddrWidth:0];
    end else begin
      count = cfg_i.word_count[mit_pkg::AddrWidth:0];
    end
    last_idx = count - 1'b1;
  end

  always_comb begin : step_comb
    mit_pkg::state_t               cur;
    mit_pkg::state_t               nxt;
    logic [mit_pkg::DataWidth-1:0] data;
    logic [mit_pkg::DataWidth-1:0] exp_data;
    logic [mit_pkg::DataWidth-1:0] wr_data;
    logic                          cmp;
    logic                          mis;
    logic [mit_pkg::AddrWidth:0]   word_inc;
    logic [mit_pkg::ShiftWidth-1:0] sp_inc;
    logic [mit_pkg::ShiftWidth-1:0] sp_dec;
    logic [mit_pkg::OffsetWidth-1:0] k;
    logic [mit_pkg::DataWidth-1:0] walk;
    logic [mit_pkg::PassWidth-1:0] passes_inc;
    logic [mit_pkg::AddrWidth-1:0] addr;
    logic [mit_pkg::AddrWidth-1:0] next_addr;

    cur = state_i;
    if (kind_i == mit_pkg::KindStart) begin
      cur.errors    = '0;
      cur.passes    = '0;
      cur.phase     = mit_pkg::PhFill;
      cur.word      = '0;
      cur.pattern   = cfg_i.first_pattern;
      cur.shift_pos = {1'b0, cfg_i.start_offset};
    end
    nxt = cur;

    data = cfg_i.pattern_mode ? cur.pattern : cfg_i.first_pattern;
    case (cur.phase)
      mit_pkg::PhFill: begin
        exp_data = '0;
        wr_data  = data;
        cmp      = 1'b0;
      end
      mit_pkg::PhAsc: begin
        exp_data = data;
        wr_data  = ~data;
        cmp      = 1'b1;
      end
      mit_pkg::PhDesc: begin
        exp_data = ~data;
        wr_data  = data;
        cmp      = 1'b1;
      end
      default: begin
        exp_data = '0;
        wr_data  = '0;
        cmp      = 1'b0;
      end
    endcase

    mis = cmp && (read_data_i != exp_data);
    if (mis && (cur.errors != '1)) begin
      nxt.errors = cur.errors + 1'b1;
    end

    addr       = mit_pkg::AddrWidth'(cfg_i.base_address) + cur.word;
    word_inc   = {1'b0, cur.word} + 1'b1;
    sp_inc     = cur.shift_pos + 1'b1;
    passes_inc = cur.passes + 1'b1;

    // step the shift position upward and form the walking bit that starts the descent
    if (sp_inc >= mit_pkg::ShiftTop) begin
      sp_dec = '0;
    end else begin
      sp_dec = sp_inc;
    end
    k    = mit_pkg::OffsetWidth'(sp_dec - 1'b1);
    walk = mit_pkg::DataWidth'(1) << k;

    case (cur.phase)
      mit_pkg::PhFill, mit_pkg::PhAsc: begin
        if (sp_inc >= mit_pkg::ShiftTop) begin
          nxt.pattern   = cfg_i.shift_fill ? mit_pkg::LowWalkZero : mit_pkg::LowWalkOne;
          nxt.shift_pos = '0;
        end else begin
          nxt.pattern   = {cur.pattern[mit_pkg::DataWidth-2:0], cfg_i.shift_fill};
          nxt.shift_pos = sp_inc;
        end
        if (word_inc < count) begin
          nxt.word = word_inc[mit_pkg::AddrWidth-1:0];
        end else if (cur.phase == mit_pkg::PhFill) begin
          if (cfg_i.iteration_count == '0) begin
            nxt.phase = mit_pkg::PhIdle;
          end else begin
            nxt.phase     = mit_pkg::PhAsc;
            nxt.word      = '0;
            nxt.pattern   = cfg_i.first_pattern;
            nxt.shift_pos = {1'b0, cfg_i.start_offset};
          end
        end else begin
          nxt.phase     = mit_pkg::PhDesc;
          nxt.word      = last_idx[mit_pkg::AddrWidth-1:0];
          nxt.pattern   = cfg_i.shift_fill ? ~walk : walk;
          nxt.shift_pos = {1'b0, k} + 1'b1;
        end
      end
      mit_pkg::PhDesc: begin
        if (cur.shift_pos <= mit_pkg::ShiftWidth'(1)) begin
          nxt.pattern   = cfg_i.shift_fill ? mit_pkg::TopWalkZero : mit_pkg::TopWalkOne;
          nxt.shift_pos = mit_pkg::ShiftTop;
        end else begin
          nxt.pattern   = {cfg_i.shift_fill, cur.pattern[mit_pkg::DataWidth-1:1]};
          nxt.shift_pos = cur.shift_pos - 1'b1;
        end
        if (cur.word == '0) begin
          nxt.passes = passes_inc;
          if (passes_inc >= cfg_i.iteration_count) begin
            nxt.phase = mit_pkg::PhIdle;
          end else begin
            nxt.phase     = mit_pkg::PhAsc;
            nxt.word      = '0;
            nxt.pattern   = cfg_i.first_pattern;
            nxt.shift_pos = {1'b0, cfg_i.start_offset};
          end
        end else begin
          nxt.word = cur.word - 1'b1;
        end
      end
      default: begin
      end
    endcase

    next_addr = mit_pkg::AddrWidth'(cfg_i.base_address) + nxt.word;

    result_o = '0;
    if (cur.phase == mit_pkg::PhIdle) begin
      result_o.error_total = cur.errors;
      result_o.run_done    = 1'b1;
      state_o              = cur;
    end else begin
      result_o.word_address  = mit_pkg::FieldAddrW'(addr);
      result_o.write_enable  = 1'b1;
      result_o.write_data    = wr_data;
      result_o.expected_data = exp_data;
      result_o.compare_valid = cmp;
      result_o.mismatch      = mis;
      result_o.error_total   = nxt.errors;
      if (nxt.phase == mit_pkg::PhIdle) begin
        result_o.run_done = 1'b1;
      end else begin
        result_o.next_address = mit_pkg::FieldAddrW'(next_addr);
      end
      state_o = nxt;
    end
  end

endmodule

### verif/moving_inversions_memory_test_unit_test.sv
// Self-checking testbench for the moving inversions memory self-test unit.
`timescale 1ns / 1ps

module moving_inversions_memory_test_unit_test;
  import mit_pkg::*;

  class march_predictor;
    cfg_t                  regs;
    phase_e                phase;
    logic [AddrWidth-1:0]  word;
    logic [ShiftWidth-1:0] shift_pos;
    logic [DataWidth-1:0]  pattern;
    logic [PassWidth-1:0]  passes;
    logic [DataWidth-1:0]  errors;
    result_t               due_steps[$];
    int                    faults;
    int                    reports;

    function new();
      regs = '0;
      regs.word_count = 31'd1;
      regs.iteration_count = 8'd1;
      phase = PhIdle;
      word = '0;
      shift_pos = '0;
      pattern = '0;
      passes = '0;
      errors = '0;
      faults = 0;
      reports = 0;
    endfunction

    function void write_reg(logic [CfgIdxWidth-1:0] idx, logic [DataWidth-1:0] data);
      case (idx)
        RegBaseAddress:    regs.base_address = data[FieldAddrW-1:0];
        RegWordCount:      regs.word_count = data[CountWidth-1:0];
        RegFirstPattern:   regs.first_pattern = data;
        RegShiftFill:      regs.shift_fill = data[0];
        RegStartOffset:    regs.start_offset = data[OffsetWidth-1:0];
        RegIterationCount: regs.iteration_count = data[PassWidth-1:0];
        RegPatternMode:    regs.pattern_mode = data[0];
        default: ;
      endcase
    endfunction

    function logic [AddrWidth-1:0] word_addr(logic [AddrWidth-1:0] idx);
      return regs.base_address + idx;
    endfunction

    function logic [CountWidth-1:0] span();
      logic [CountWidth-1:0] c;
      c = regs.word_count;
      if (c == '0) c = 31'd1;
      if (c > WordLimit) c = WordLimit;
      return c;
    endfunction

    function bit busy();
      return phase != PhIdle;
    endfunction

    function logic [AddrWidth-1:0] read_address();
      return word_addr(word);
    endfunction

    function void enter_ascent();
      phase = PhAsc;
      word = '0;
      pattern = regs.first_pattern;
      shift_pos = {1'b0, regs.start_offset};
    endfunction

    function void enter_descent(logic [CountWidth-1:0] n);
      logic [4:0]           k;
      logic [DataWidth-1:0] p;
      k = shift_pos[4:0] - 5'd1;
      p = regs.shift_fill ? LowWalkZero : LowWalkOne;
      if (k != 5'd0) begin
        p = p << k;
        if (regs.shift_fill) p = p | ((32'd1 << k) - 32'd1);
      end
      pattern = p;
      shift_pos = {1'b0, k} + 6'd1;
      phase = PhDesc;
      word = n[AddrWidth-1:0] - 30'd1;
    endfunction

    function void shift_up();
      if (shift_pos + 6'd1 >= ShiftTop) begin
        pattern = regs.shift_fill ? LowWalkZero : LowWalkOne;
        shift_pos = '0;
      end else begin
        pattern = {pattern[DataWidth-2:0], regs.shift_fill};
        shift_pos = shift_pos + 6'd1;
      end
    endfunction

    function void shift_down();
      if (shift_pos <= 6'd1) begin
        pattern = regs.shift_fill ? TopWalkZero : TopWalkOne;
        shift_pos = ShiftTop;
      end else begin
        pattern = {regs.shift_fill, pattern[DataWidth-1:1]};
        shift_pos = shift_pos - 6'd1;
      end
    endfunction

    function result_t note_item(logic k, logic [DataWidth-1:0] rd);
      result_t               r;
      logic [CountWidth-1:0] n;
      logic [DataWidth-1:0]  data;
      phase_e                ph;
      r = '0;
      if (k == KindStart) begin
        errors = '0;
        passes = '0;
        phase = PhFill;
        word = '0;
        pattern = regs.first_pattern;
        shift_pos = {1'b0, regs.start_offset};
      end
      if (phase == PhIdle) begin
        r.error_total = errors;
        r.run_done = 1'b1;
        due_steps.push_back(r);
        return r;
      end
      n = span();
      ph = phase;
      r.word_address = word_addr(word);
      r.write_enable = 1'b1;
      data = regs.pattern_mode ? pattern : regs.first_pattern;
      case (ph)
        PhFill: r.write_data = data;
        PhAsc: begin
          r.expected_data = data;
          r.write_data = ~data;
          r.compare_valid = 1'b1;
        end
        default: begin
          r.expected_data = ~data;
          r.write_data = data;
          r.compare_valid = 1'b1;
        end
      endcase
      if (r.compare_valid && rd != r.expected_data) begin
        r.mismatch = 1'b1;
        if (errors != '1) errors = errors + 32'd1;
      end
      if (ph != PhDesc) begin
        shift_up();
        if ({1'b0, word} + 31'd1 < n) begin
          word = word + 30'd1;
        end else if (ph == PhFill) begin
          if (regs.iteration_count == '0) phase = PhIdle;
          else enter_ascent();
        end else begin
          enter_descent(n);
        end
      end else begin
        shift_down();
        if (word == '0) begin
          passes = passes + 8'd1;
          if (passes >= regs.iteration_count) phase = PhIdle;
          else enter_ascent();
        end else begin
          word = word - 30'd1;
        end
      end
      r.next_address = (phase == PhIdle) ? '0 : word_addr(word);
      r.error_total = errors;
      r.run_done = (phase == PhIdle);
      due_steps.push_back(r);
      return r;
    endfunction

    function bit field_ok(string label, logic [DataWidth-1:0] want, logic [DataWidth-1:0] got);
      if (got === want) return 1'b1;
      if (reports < 10) begin
        $display("%0t: %s expected %h got %h", $time, label, want, got);
      end
      reports++;
      return 1'b0;
    endfunction

    function void check_step(result_t got);
      result_t want;
      bit      ok;
      if (due_steps.size() == 0) begin
        faults++;
        if (reports < 10) begin
          $display("%0t: unexpected result at word_address %h", $time, got.word_address);
        end
        reports++;
        return;
      end
      want = due_steps.pop_front();
      ok = field_ok("word_address", 32'(want.word_address), 32'(got.word_address));
      ok = field_ok("write_enable", 32'(want.write_enable), 32'(got.write_enable)) && ok;
      ok = field_ok("write_data", want.write_data, got.write_data) && ok;
      ok = field_ok("expected_data", want.expected_data, got.expected_data) && ok;
      ok = field_ok("compare_valid", 32'(want.compare_valid), 32'(got.compare_valid)) && ok;
      ok = field_ok("mismatch", 32'(want.mismatch), 32'(got.mismatch)) && ok;
      ok = field_ok("next_address", 32'(want.next_address), 32'(got.next_address)) && ok;
      ok = field_ok("error_total", want.error_total, got.error_total) && ok;
      ok = field_ok("run_done", 32'(want.run_done), 32'(got.run_done)) && ok;
      if (!ok) faults++;
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic                   kind_i;
  logic [DataWidth-1:0]   read_data_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [FieldAddrW-1:0]  word_address_o;
  logic                   write_enable_o;
  logic [DataWidth-1:0]   write_data_o;
  logic [DataWidth-1:0]   expected_data_o;
  logic                   compare_valid_o;
  logic                   mismatch_o;
  logic [FieldAddrW-1:0]  next_address_o;
  logic [DataWidth-1:0]   error_total_o;
  logic                   run_done_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CfgIdxWidth-1:0] cfg_index_i;
  logic [DataWidth-1:0]   cfg_data_i;

  march_predictor         sb = new();
  logic [DataWidth-1:0]   mem_words [logic [AddrWidth-1:0]];
  result_t                seen;
  bit                     calm = 1'b0;
  int                     items_done = 0;

  moving_inversions_memory_test_unit uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  assign seen = '{word_address: word_address_o, write_enable: write_enable_o,
                  write_data: write_data_o, expected_data: expected_data_o,
                  compare_valid: compare_valid_o, mismatch: mismatch_o,
                  next_address: next_address_o, error_total: error_total_o,
                  run_done: run_done_o};

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_step(seen);
  end

  function automatic int burst_len();
    if ($urandom_range(9, 0) == 0) return $urandom_range(30, 8);
    return $urandom_range(3, 1);
  endfunction

  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      repeat (burst_len()) @(posedge clk_i);
      if (!calm) begin
        out_stall_i <= 1'b1;
        repeat (burst_len()) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_item(input logic k, input logic [DataWidth-1:0] flip);
    int                   gap;
    logic [DataWidth-1:0] rd;
    logic [AddrWidth-1:0] a;
    result_t              r;
    bit                   counted;
    gap = (calm || $urandom_range(9, 0) < 6) ? 0 : burst_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    a = sb.read_address();
    if (k == KindStart || !mem_words.exists(a)) rd = $urandom();
    else rd = mem_words[a];
    rd = rd ^ flip;
    in_valid_i <= 1'b1;
    kind_i <= k;
    read_data_i <= rd;
    do @(posedge clk_i); while (in_stall_o);
    counted = (k == KindStart) || sb.busy();
    r = sb.note_item(k, rd);
    if (r.write_enable) mem_words[r.word_address] = r.write_data;
    if (counted) items_done++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.due_steps.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic load_config(input cfg_t c, input logic [6:0] sel);
    logic [DataWidth-1:0]   v;
    logic [CfgIdxWidth-1:0] idx;
    for (int i = 0; i < 7; i++) begin
      if (!sel[i]) continue;
      idx = CfgIdxWidth'(i);
      case (idx)
        RegBaseAddress:    v = 32'(c.base_address);
        RegWordCount:      v = 32'(c.word_count);
        RegFirstPattern:   v = c.first_pattern;
        RegShiftFill:      v = 32'(c.shift_fill);
        RegStartOffset:    v = 32'(c.start_offset);
        RegIterationCount: v = 32'(c.iteration_count);
        RegPatternMode:    v = 32'(c.pattern_mode);
        default:           v = '0;
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i <= v;
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.write_reg(idx, v);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [DataWidth-1:0] corruption();
    if ($urandom_range(1, 0) == 0) return 32'd1 << $urandom_range(31, 0);
    return $urandom() | 32'd1;
  endfunction

  function automatic cfg_t pick_config();
    cfg_t c;
    int   r;
    case ($urandom_range(3, 0))
      0: c.base_address = '0;
      1: c.base_address = '1;
      2: c.base_address = 30'h3fff_ffff - 30'($urandom_range(8, 0));
      default: c.base_address = 30'($urandom());
    endcase
    r = $urandom_range(19, 0);
    if (r == 0) c.word_count = '0;
    else if (r == 1) c.word_count = 31'h7fff_ffff;
    else if (r == 2) c.word_count = 31'h4000_0000;
    else if (r == 3) c.word_count = 31'h4000_0001;
    else if (r < 12) c.word_count = 31'($urandom_range(8, 1));
    else c.word_count = 31'($urandom_range(40, 1));
    case ($urandom_range(3, 0))
      0: c.first_pattern = '0;
      1: c.first_pattern = '1;
      default: c.first_pattern = $urandom();
    endcase
    c.shift_fill = 1'($urandom_range(1, 0));
    case ($urandom_range(3, 0))
      0: c.start_offset = '0;
      1: c.start_offset = '1;
      default: c.start_offset = 5'($urandom_range(31, 0));
    endcase
    r = $urandom_range(11, 0);
    if (r == 0) c.iteration_count = '0;
    else if (r == 1) c.iteration_count = '1;
    else if (r < 4) c.iteration_count = 8'($urandom());
    else c.iteration_count = 8'($urandom_range(4, 1));
    c.pattern_mode = 1'($urandom_range(1, 0));
    return c;
  endfunction

  task automatic random_phase();
    cfg_t                 c;
    logic [6:0]           sel;
    int                   budget;
    int                   noise_pct;
    logic                 k;
    logic [DataWidth-1:0] flip;
    c = pick_config();
    sel = ($urandom_range(3, 0) != 0) ? 7'h7f : 7'($urandom_range(127, 1));
    drain();
    load_config(c, sel);
    calm = ($urandom_range(4, 0) == 0);
    noise_pct = ($urandom_range(5, 0) == 0) ? 30 : 3;
    budget = $urandom_range(120, 20);
    if (sel == 7'h7f || $urandom_range(2, 0) == 0) send_item(KindStart, '0);
    repeat (budget) begin
      if (!sb.busy()) k = ($urandom_range(6, 0) == 0) ? KindRead : KindStart;
      else k = ($urandom_range(40, 0) == 0) ? KindStart : KindRead;
      flip = '0;
      if (k == KindRead && $urandom_range(99, 0) < noise_pct) flip = corruption();
      send_item(k, flip);
    end
  endtask

  initial begin
    cfg_t c;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = KindRead;
    read_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegBaseAddress;
    cfg_data_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults after reset: one word, one iteration
    send_item(KindRead, '0);
    send_item(KindStart, '0);
    send_item(KindRead, '0);
    send_item(KindRead, '0);
    send_item(KindRead, '1);

    // address wrap at the top, walking zero, no check passes
    c = '{base_address: 30'h3fff_fffe, word_count: 31'd3, first_pattern: '1,
          shift_fill: 1'b1, start_offset: 5'd31, iteration_count: 8'd0, pattern_mode: 1'b1};
    drain();
    load_config(c, 7'h7f);
    send_item(KindStart, '0);
    send_item(KindRead, '0);
    send_item(KindRead, '0);
    send_item(KindRead, '1);

    // zero word count, every check read wrong
    c = '{base_address: '0, word_count: '0, first_pattern: '0, shift_fill: 1'b0,
          start_offset: 5'd0, iteration_count: 8'd2, pattern_mode: 1'b0};
    drain();
    load_config(c, 7'h7f);
    send_item(KindStart, '0);
    send_item(KindRead, '1);
    send_item(KindRead, 32'h8000_0000);
    send_item(KindRead, 32'h0000_0001);
    send_item(KindRead, 32'h5555_aaaa);

    // oversized word count, restart in the middle of the fill pass
    c = '{base_address: 30'h0000_1234, word_count: 31'h7fff_ffff, first_pattern: 32'h8000_0001,
          shift_fill: 1'b0, start_offset: 5'd0, iteration_count: 8'd255, pattern_mode: 1'b1};
    drain();
    load_config(c, 7'h7f);
    send_item(KindStart, '0);
    repeat (5) send_item(KindRead, '0);
    send_item(KindStart, '0);
    send_item(KindRead, '0);

    // full run at the largest iteration count
    c = '{base_address: 30'h2aaa_aaaa, word_count: 31'd1, first_pattern: $urandom(),
          shift_fill: 1'b1, start_offset: 5'd31, iteration_count: 8'd255, pattern_mode: 1'b1};
    drain();
    load_config(c, 7'h7f);
    send_item(KindStart, '0);
    while (sb.busy()) begin
      send_item(KindRead, ($urandom_range(49, 0) == 0) ? corruption() : '0);
    end
    send_item(KindRead, '0);

    while (items_done < 1900) random_phase();

    calm = 1'b0;
    drain();
    repeat (10) @(posedge clk_i);
    if (sb.faults == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
